@@ rtl/priority_time_window_table_search_unit_macros.svh @@
// assertion macros for the priority time window table search unit
`ifndef PRIORITY_TIME_WINDOW_TABLE_SEARCH_UNIT_MACROS_SVH
`define PRIORITY_TIME_WINDOW_TABLE_SEARCH_UNIT_MACROS_SVH
`ifndef SYNTH
`define PTWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptws check failed");
`define PTWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptws check failed");
`else
`define PTWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PTWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/ptws_pkg.sv @@
// shared types and constants of the priority time window table search unit
`default_nettype none
package ptws_pkg;
    localparam int IDX_W    = 10;
    localparam int KEY_W    = 32;
    localparam int TIME_W   = 47;
    localparam int PRIO_W   = 16;
    localparam int CODE_W   = 32;
    localparam int CNT_W    = 11;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 264;
    localparam int M_DATA_W = 184;
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIRST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LOADED   = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] stop;
        logic              open;
        logic [PRIO_W-1:0] prio;
        logic [CODE_W-1:0] tariff;
        logic [CODE_W-1:0] formula;
    } entry_t;

    typedef struct packed {
        logic                load_wr;
        logic                bs_init;
        logic                bs_rd;
        logic                bs_lo;
        logic                bs_hi;
        logic                cur_ld;
        logic                fw_rd;
        logic                fw_step;
        logic                top_ld;
        logic                wk_rd;
        logic                hit;
        logic                nx_rd;
        logic                walk_end;
        logic                res_ld;
        logic [STATUS_W-1:0] res_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic bs_more;
        logic bs_gt;
        logic bs_eq;
        logic fw_more;
        logic fw_same;
        logic wk_ok;
        logic holds;
        logic pos_zero;
        logic walk_done;
        logic cur_key_eq;
        logic cursor_end;
        logic out_free;
    } dp_sts_t;
endpackage
`default_nettype wire

@@ rtl/ptws_datapath.sv @@
// table memory, search registers and result register
`default_nettype none
module ptws_datapath #(
    parameter int TABLE_DEPTH = ptws_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ptws_pkg::dp_cmd_t             dp_cmd,
    output ptws_pkg::dp_sts_t                  dp_sts,
    input  wire logic                          cfg_we,
    input  wire logic [ptws_pkg::CNT_W-1:0]    cfg_wdata,
    input  wire logic [ptws_pkg::IDX_W-1:0]    in_index,
    input  wire ptws_pkg::entry_t              in_entry,
    input  wire logic [ptws_pkg::TIME_W-1:0]   in_query,
    input  wire logic                          m_tready,
    output logic                               m_valid,
    output logic [ptws_pkg::STATUS_W-1:0]      m_status,
    output logic [ptws_pkg::IDX_W-1:0]         m_index,
    output ptws_pkg::entry_t                   m_entry
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = AW + 1;

    ptws_pkg::entry_t mem [TABLE_DEPTH];
    ptws_pkg::entry_t rdata_reg, cur_reg, m_entry_reg, found_entry;
    logic [PW-1:0] lo_reg, hx_reg, pos_reg, n_reg, n_now, mid, pos_inc, pos_dec;
    logic [PW:0]   mid_sum;
    logic [ptws_pkg::IDX_W-1:0] cursor_reg, cursor_dec, m_index_reg;
    logic [ptws_pkg::KEY_W-1:0] key_reg;
    logic [ptws_pkg::TIME_W-1:0] time_reg;
    logic [ptws_pkg::PRIO_W-1:0] top_reg;
    logic [ptws_pkg::CNT_W-1:0] cnt_reg;
    logic [ptws_pkg::STATUS_W-1:0] m_status_reg;
    logic done_reg, m_valid_reg, rd_en, slot_ok;
    logic [AW-1:0] raddr;

    assign n_now      = (32'(cnt_reg) > TABLE_DEPTH) ? PW'(TABLE_DEPTH) : PW'(cnt_reg);
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hx_reg} - (PW+1)'(1);
    assign mid        = mid_sum[PW:1];
    assign pos_inc    = pos_reg + PW'(1);
    assign pos_dec    = pos_reg - PW'(1);
    assign cursor_dec = cursor_reg - ptws_pkg::IDX_W'(1);
    assign rd_en      = dp_cmd.bs_rd | dp_cmd.fw_rd | dp_cmd.wk_rd | dp_cmd.nx_rd;
    assign slot_ok    = 32'(in_index) < TABLE_DEPTH;

    always_comb begin
        priority if (dp_cmd.bs_rd) begin
            raddr = mid[AW-1:0];
        end else if (dp_cmd.fw_rd) begin
            raddr = pos_inc[AW-1:0];
        end else if (dp_cmd.wk_rd) begin
            raddr = pos_dec[AW-1:0];
        end else begin
            raddr = AW'(cursor_dec);
        end
    end

    // open ended entries report a zero end time
    always_comb begin
        found_entry = cur_reg;
        if (cur_reg.open) begin
            found_entry.stop = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load_wr && slot_ok) begin
            mem[AW'(in_index)] <= in_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.cur_ld) begin
            cur_reg <= rdata_reg;
        end
        if (dp_cmd.top_ld) begin
            top_reg <= cur_reg.prio;
        end
        if (dp_cmd.bs_init) begin
            lo_reg <= '0;
            hx_reg <= n_now;
            n_reg  <= n_now;
        end
        if (dp_cmd.bs_lo) begin
            lo_reg <= pos_inc;
        end
        if (dp_cmd.bs_hi) begin
            hx_reg <= pos_reg;
        end
        if (dp_cmd.bs_rd) begin
            pos_reg <= mid;
        end else if (dp_cmd.fw_step) begin
            pos_reg <= pos_inc;
        end else if (dp_cmd.wk_rd) begin
            pos_reg <= pos_dec;
        end
        if (dp_cmd.res_ld) begin
            m_status_reg <= dp_cmd.res_kind;
            if (dp_cmd.res_kind == ptws_pkg::STATUS_FOUND) begin
                m_index_reg <= cursor_reg;
                m_entry_reg <= found_entry;
            end else begin
                m_index_reg <= '0;
                m_entry_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            key_reg     <= '0;
            time_reg    <= '0;
            cursor_reg  <= '0;
            done_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cnt_reg <= cfg_wdata;
            end
            if (dp_cmd.bs_init) begin
                key_reg  <= in_entry.key;
                time_reg <= in_query;
                done_reg <= 1'b1;
            end
            if (dp_cmd.hit) begin
                cursor_reg <= ptws_pkg::IDX_W'(pos_reg);
                done_reg   <= 1'b0;
            end else if (dp_cmd.nx_rd) begin
                cursor_reg <= cursor_dec;
            end
            if (dp_cmd.walk_end) begin
                done_reg <= 1'b1;
            end
            if (dp_cmd.res_ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        dp_sts.bs_more    = lo_reg < hx_reg;
        dp_sts.bs_gt      = key_reg > rdata_reg.key;
        dp_sts.bs_eq      = key_reg == rdata_reg.key;
        dp_sts.fw_more    = pos_inc < n_reg;
        dp_sts.fw_same    = rdata_reg.key == key_reg;
        dp_sts.wk_ok      = (cur_reg.key == key_reg) && (cur_reg.prio == top_reg);
        dp_sts.holds      = (time_reg >= cur_reg.start) &&
                            (cur_reg.open || (time_reg <= cur_reg.stop));
        dp_sts.pos_zero   = pos_reg == '0;
        dp_sts.walk_done  = done_reg;
        dp_sts.cur_key_eq = cur_reg.key == key_reg;
        dp_sts.cursor_end = (cursor_reg == '0) || (32'(cursor_reg) >= TABLE_DEPTH);
        dp_sts.out_free   = !m_valid_reg || m_tready;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_index  = m_index_reg;
    assign m_entry  = m_entry_reg;
endmodule
`default_nettype wire

@@ rtl/ptws_controller.sv @@
// search sequencer state machine
`default_nettype none
`include "priority_time_window_table_search_unit_macros.svh"
module ptws_controller (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [ptws_pkg::CMD_W-1:0]  s_cmd,
    output ptws_pkg::dp_cmd_t                dp_cmd,
    input  wire ptws_pkg::dp_sts_t           dp_sts
);
    typedef enum logic [3:0] {
        IDLE, BS_RD, BS_EV, FW_RD, FW_EV, WK_EV, WK_RD, WK_LT,
        NX_TST, NX_LT, NX_EV, RESP
    } state_t;

    state_t state_reg, state_next;
    logic [ptws_pkg::STATUS_W-1:0] kind_reg, kind_next;
    logic load_acc, load_done;

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        dp_cmd     = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    kind_next  = ptws_pkg::STATUS_NOTFOUND;
                    state_next = RESP;
                    unique case (s_cmd)
                        ptws_pkg::CMD_LOAD: begin
                            dp_cmd.load_wr = 1'b1;
                            kind_next      = ptws_pkg::STATUS_LOADED;
                        end
                        ptws_pkg::CMD_FIRST: begin
                            dp_cmd.bs_init = 1'b1;
                            state_next     = BS_RD;
                        end
                        ptws_pkg::CMD_NEXT: begin
                            if (!dp_sts.walk_done) begin
                                state_next = NX_TST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BS_RD: begin
                if (dp_sts.bs_more) begin
                    dp_cmd.bs_rd = 1'b1;
                    state_next   = BS_EV;
                end else begin
                    kind_next  = ptws_pkg::STATUS_NOTFOUND;
                    state_next = RESP;
                end
            end
            BS_EV: begin
                priority if (dp_sts.bs_eq) begin
                    dp_cmd.cur_ld = 1'b1;
                    state_next    = FW_RD;
                end else if (dp_sts.bs_gt) begin
                    dp_cmd.bs_lo = 1'b1;
                    state_next   = BS_RD;
                end else begin
                    dp_cmd.bs_hi = 1'b1;
                    state_next   = BS_RD;
                end
            end
            FW_RD: begin
                if (dp_sts.fw_more) begin
                    dp_cmd.fw_rd = 1'b1;
                    state_next   = FW_EV;
                end else begin
                    dp_cmd.top_ld = 1'b1;
                    state_next    = WK_EV;
                end
            end
            FW_EV: begin
                if (dp_sts.fw_same) begin
                    dp_cmd.fw_step = 1'b1;
                    dp_cmd.cur_ld  = 1'b1;
                    state_next     = FW_RD;
                end else begin
                    dp_cmd.top_ld = 1'b1;
                    state_next    = WK_EV;
                end
            end
            WK_EV: begin
                priority if (!dp_sts.wk_ok) begin
                    kind_next  = ptws_pkg::STATUS_NOTFOUND;
                    state_next = RESP;
                end else if (dp_sts.holds) begin
                    dp_cmd.hit = 1'b1;
                    kind_next  = ptws_pkg::STATUS_FOUND;
                    state_next = RESP;
                end else if (dp_sts.pos_zero) begin
                    kind_next  = ptws_pkg::STATUS_NOTFOUND;
                    state_next = RESP;
                end else begin
                    state_next = WK_RD;
                end
            end
            WK_RD: begin
                dp_cmd.wk_rd = 1'b1;
                state_next   = WK_LT;
            end
            WK_LT: begin
                dp_cmd.cur_ld = 1'b1;
                state_next    = WK_EV;
            end
            NX_TST: begin
                if (dp_sts.cursor_end) begin
                    dp_cmd.walk_end = 1'b1;
                    kind_next       = ptws_pkg::STATUS_NOTFOUND;
                    state_next      = RESP;
                end else begin
                    dp_cmd.nx_rd = 1'b1;
                    state_next   = NX_LT;
                end
            end
            NX_LT: begin
                dp_cmd.cur_ld = 1'b1;
                state_next    = NX_EV;
            end
            NX_EV: begin
                priority if (!dp_sts.cur_key_eq) begin
                    dp_cmd.walk_end = 1'b1;
                    kind_next       = ptws_pkg::STATUS_NOTFOUND;
                    state_next      = RESP;
                end else if (dp_sts.holds) begin
                    kind_next  = ptws_pkg::STATUS_FOUND;
                    state_next = RESP;
                end else begin
                    state_next = NX_TST;
                end
            end
            RESP: begin
                if (dp_sts.out_free) begin
                    dp_cmd.res_ld = 1'b1;
                    state_next    = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
        dp_cmd.res_kind = kind_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            kind_reg  <= ptws_pkg::STATUS_NOTFOUND;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign load_acc  = s_tvalid && s_tready && (s_cmd == ptws_pkg::CMD_LOAD);
    assign load_done = (state_reg == RESP) && (kind_reg == ptws_pkg::STATUS_LOADED);

    `PTWS_ASSERT_IMP(a_res_free, aclk, aresetn, dp_cmd.res_ld, dp_sts.out_free)
    `PTWS_ASSERT_IMP(a_bs_range, aclk, aresetn, dp_cmd.bs_rd, dp_sts.bs_more)
    `PTWS_ASSERT_NXT(a_load_resp, aclk, aresetn, load_acc, load_done)
endmodule
`default_nettype wire

@@ rtl/priority_time_window_table_search_unit.sv @@
// top level of the priority time window table search unit
// channels: s_ carries one command transaction (tuser = cmd) with the entry
// and query fields in tdata; m_ returns exactly one result transaction per
// command (tuser = status) with the match fields in tdata. cfg_we/cfg_wdata
// write entry_count; the user must do this only while the unit is idle,
// which the block does not enforce. one command is processed at a time;
// s_tready is high only when idle. a load writes the table entry and then
// passes through the response state to its result register. a first lookup
// runs a binary search (log2 of entry_count probes), skips forward over
// entries with equal keys and then walks backward; a next lookup walks
// entries backward. the table memory has a single read port with registered
// read data. reset clears entry_count, the walk state and the output valid;
// table contents are kept undefined until loaded. when m_tready is low the
// result waits in the output register; the next command is still accepted,
// but its result is held back until the register is free.
`default_nettype none
module priority_time_window_table_search_unit #(
    parameter int TABLE_DEPTH = ptws_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [ptws_pkg::CNT_W-1:0]     cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // entry_index, group_key, window_start, window_end, end_open,
    // priority_req, tariff_code, formula_code, query_time
    input  wire logic [ptws_pkg::S_DATA_W-1:0]  s_tdata,
    // cmd
    input  wire logic [ptws_pkg::CMD_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // match_index, match_priority, match_tariff, match_formula,
    // match_start, match_end
    output logic [ptws_pkg::M_DATA_W-1:0]       m_tdata,
    // status
    output logic [ptws_pkg::STATUS_W-1:0]       m_tuser
);
    ptws_pkg::dp_cmd_t dp_cmd;
    ptws_pkg::dp_sts_t dp_sts;
    ptws_pkg::entry_t  in_entry, m_entry;
    logic [ptws_pkg::IDX_W-1:0] m_index;

    always_comb begin
        in_entry.key     = s_tdata[41:10];
        in_entry.start   = s_tdata[88:42];
        in_entry.stop    = s_tdata[135:89];
        in_entry.open    = s_tdata[136];
        in_entry.prio    = s_tdata[152:137];
        in_entry.tariff  = s_tdata[184:153];
        in_entry.formula = s_tdata[216:185];
    end

    assign m_tdata = {m_entry.stop, m_entry.start, m_entry.formula, m_entry.tariff,
                      m_entry.prio, m_index};

    ptws_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .dp_cmd   (dp_cmd),
        .dp_sts   (dp_sts)
    );

    ptws_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dp_cmd    (dp_cmd),
        .dp_sts    (dp_sts),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_index  (s_tdata[9:0]),
        .in_entry  (in_entry),
        .in_query  (s_tdata[263:217]),
        .m_tready  (m_tready),
        .m_valid   (m_tvalid),
        .m_status  (m_tuser),
        .m_index   (m_index),
        .m_entry   (m_entry)
    );
endmodule
`default_nettype wire
